>>> rtl/bse_pkg.sv
package bse_pkg;

    localparam int FUNC_W = 3;
    localparam int ELEM_W = 10;
    localparam int SIZE_W = 11;
    localparam int POS_W  = SIZE_W + 1;
    localparam int Q_W    = 7;

    localparam logic [SIZE_W-1:0] SIZE_RESET  = 11'd1024;
    localparam logic [SIZE_W-1:0] MAX_MEMBERS = 11'd1024;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEL   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEST  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FIND  = 3'd4;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SPLIT,
        ST_MODIFY,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

>>> rtl/bse_if.sv
interface bse_cmd_if;
    import bse_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ELEM_W-1:0] element;

    modport source (output valid, output func, output element, input ready);
    modport sink   (input valid, input func, input element, output ready);
endinterface

interface bse_res_if;
    import bse_pkg::*;

    logic              valid;
    logic              ready;
    logic              was_member;
    logic              found;
    logic [ELEM_W-1:0] found_index;
    logic [SIZE_W-1:0] member_count;
    logic              out_of_range;

    modport source (output valid, output was_member, output found, output found_index,
                    output member_count, output out_of_range, input ready);
    modport sink   (input valid, input was_member, input found, input found_index,
                    input member_count, input out_of_range, output ready);
endinterface

interface bse_cfg_if;
    import bse_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] size_in_use;

    modport source (output valid, output size_in_use, input ready);
    modport sink   (input valid, input size_in_use, output ready);
endinterface

>>> rtl/bse_ram.sv
module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/bse_split.sv
// Splits an element index into word address, bit offset and word base position.
module bse_split #(
    parameter int WORD_BITS = 32
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [bse_pkg::ELEM_W-1:0]                  element,
    output logic                                        done,
    output logic [bse_pkg::Q_W-1:0]                     word,
    output logic [(WORD_BITS > 1 ? $clog2(WORD_BITS) : 1)-1:0] offset,
    output logic [bse_pkg::POS_W-1:0]                   base
);
    import bse_pkg::*;

    localparam int OFF_W = WORD_BITS > 1 ? $clog2(WORD_BITS) : 1;
    localparam int SHIFT = 24;
    localparam int unsigned RECIP = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RCP_W = $clog2(RECIP + 1);

    logic              v1_reg, v2_reg, v3_reg;
    logic [ELEM_W-1:0] e_reg;
    logic [Q_W-1:0]    q0_reg;
    logic [Q_W-1:0]    word_reg;
    logic [OFF_W-1:0]  offset_reg;
    logic [POS_W-1:0]  base_reg;

    logic [ELEM_W+RCP_W-1:0] prod;
    logic [POS_W-1:0]        qwb;
    logic [POS_W-1:0]        rem;
    logic                    fix;

    // reciprocal multiply, then one correction step
    assign prod = (ELEM_W+RCP_W)'(e_reg) * (ELEM_W+RCP_W)'(RECIP);
    assign qwb  = POS_W'(q0_reg) * POS_W'(WORD_BITS);
    assign rem  = POS_W'(e_reg) - qwb;
    assign fix  = rem >= POS_W'(WORD_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            e_reg <= element;
        end
        if (v1_reg)
        begin
            q0_reg <= Q_W'(prod >> SHIFT);
        end
        if (v2_reg)
        begin
            word_reg   <= fix ? q0_reg + 1'b1 : q0_reg;
            offset_reg <= OFF_W'(fix ? rem - POS_W'(WORD_BITS) : rem);
            base_reg   <= fix ? qwb + POS_W'(WORD_BITS) : qwb;
        end
    end

    assign done   = v3_reg;
    assign word   = word_reg;
    assign offset = offset_reg;
    assign base   = base_reg;
endmodule

>>> rtl/bitmap_set_engine.sv
// Bit-vector set engine. Membership of elements 0..CAPACITY-1 lives in a word RAM
// of CAPACITY/WORD_BITS (rounded up) words with a running member count beside it.
// After reset the block sweeps the RAM to zero, one word per cycle, and takes no
// command until the sweep ends; configuration is taken at any time.
// One command is worked on at a time. Add, delete and test go through index split,
// one RAM read, a write-back (add or delete only, when the bit changes) and result.
// Find splits the index, then scans word after word with the mask/lowest-bit unit
// from the element up to the size limit, stopping at the first set bit.
// Clear all resets the member count and zeroes every word in a sweep. Out-of-range
// and unused commands go straight to the result. The result sits in an output
// register, so the next command may be transferred while it waits to be taken.
module bitmap_set_engine #(
    parameter int CAPACITY  = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    bse_cmd_if.sink   cmd,
    bse_res_if.source res,
    bse_cfg_if.sink   cfg
);
    import bse_pkg::*;

    localparam int NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int OFF_W     = WORD_BITS > 1 ? $clog2(WORD_BITS) : 1;
    localparam int CNT_W     = $clog2(WORD_BITS + 1);

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] total_reg, total_next;
    logic [SIZE_W-1:0] lim_reg, lim_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [WA_W-1:0]   clr_reg, clr_next;
    logic [WA_W-1:0]   addr_reg, addr_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [POS_W-1:0]  base_reg, base_next;
    logic              was_reg, was_next;
    logic              found_reg, found_next;
    logic [ELEM_W-1:0] fidx_reg, fidx_next;
    logic              oor_reg, oor_next;

    logic              res_valid_reg, res_valid_next;
    logic              res_was_reg, res_was_next;
    logic              res_found_reg, res_found_next;
    logic [ELEM_W-1:0] res_fidx_reg, res_fidx_next;
    logic [SIZE_W-1:0] res_count_reg, res_count_next;
    logic              res_oor_reg, res_oor_next;

    logic [SIZE_W-1:0]    lim;
    logic                 cmd_xfer;
    logic                 split_start;
    logic                 split_done;
    logic [Q_W-1:0]       split_word;
    logic [OFF_W-1:0]     split_offset;
    logic [POS_W-1:0]     split_base;

    logic                 ram_we, ram_re;
    logic [WA_W-1:0]      ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    logic [WORD_BITS-1:0] bit_sel;
    logic [WORD_BITS-1:0] scan_word;
    logic [WORD_BITS-1:0] scan_low;
    logic [OFF_W-1:0]     scan_idx;
    logic [POS_W-1:0]     scan_span;
    logic [CNT_W-1:0]     scan_hi;
    logic [POS_W-1:0]     next_base;

    assign lim = (32'(size_reg) > CAPACITY) ? SIZE_W'(CAPACITY) : size_reg;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    bse_split #(
        .WORD_BITS(WORD_BITS)
    ) u_split (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (split_start),
        .element(cmd.element),
        .done   (split_done),
        .word   (split_word),
        .offset (split_offset),
        .base   (split_base)
    );

    bse_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(NUM_WORDS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // scan unit: window [lo, hi) of the current word, then lowest set bit
    always_comb
    begin
        scan_span = POS_W'(lim_reg) - base_reg;
        scan_hi   = (scan_span >= POS_W'(WORD_BITS)) ? CNT_W'(WORD_BITS) : CNT_W'(scan_span);
        for (int b = 0; b < WORD_BITS; b++)
        begin
            scan_word[b] = ram_rdata[b] && (CNT_W'(b) >= CNT_W'(off_reg))
                           && (CNT_W'(b) < scan_hi);
        end
        scan_low = scan_word & (~scan_word + 1'b1);
        scan_idx = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (scan_low[b])
            begin
                scan_idx = scan_idx | OFF_W'(b);
            end
        end
        next_base = base_reg + POS_W'(WORD_BITS);
        bit_sel   = WORD_BITS'(1) << off_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            size_reg      <= SIZE_RESET;
            total_reg     <= '0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                size_reg <= cfg.size_in_use;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg       <= lim_next;
        func_reg      <= func_next;
        addr_reg      <= addr_next;
        off_reg       <= off_next;
        base_reg      <= base_next;
        was_reg       <= was_next;
        found_reg     <= found_next;
        fidx_reg      <= fidx_next;
        oor_reg       <= oor_next;
        res_was_reg   <= res_was_next;
        res_found_reg <= res_found_next;
        res_fidx_reg  <= res_fidx_next;
        res_count_reg <= res_count_next;
        res_oor_reg   <= res_oor_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        lim_next       = lim_reg;
        func_next      = func_reg;
        clr_next       = clr_reg;
        addr_next      = addr_reg;
        off_next       = off_reg;
        base_next      = base_reg;
        was_next       = was_reg;
        found_next     = found_reg;
        fidx_next      = fidx_reg;
        oor_next       = oor_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_was_next   = res_was_reg;
        res_found_next = res_found_reg;
        res_fidx_next  = res_fidx_reg;
        res_count_next = res_count_reg;
        res_oor_next   = res_oor_reg;
        split_start    = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = clr_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = WA_W'(split_word);

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == WA_W'(NUM_WORDS - 1))
                begin
                    clr_next   = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    func_next  = cmd.func;
                    lim_next   = lim;
                    was_next   = 1'b0;
                    found_next = 1'b0;
                    fidx_next  = '0;
                    oor_next   = 1'b0;
                    case (cmd.func)
                        FUNC_ADD, FUNC_DEL, FUNC_TEST, FUNC_FIND:
                        begin
                            if (SIZE_W'(cmd.element) >= lim)
                            begin
                                oor_next   = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                split_start = 1'b1;
                                state_next  = ST_SPLIT;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            total_next = '0;
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SPLIT:
            begin
                if (split_done)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = WA_W'(split_word);
                    addr_next  = WA_W'(split_word);
                    off_next   = split_offset;
                    base_next  = split_base;
                    state_next = (func_reg == FUNC_FIND) ? ST_SCAN : ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                was_next   = ram_rdata[off_reg];
                ram_waddr  = addr_reg;
                state_next = ST_DONE;
                if (func_reg == FUNC_ADD && !ram_rdata[off_reg])
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata | bit_sel;
                    total_next = total_reg + 1'b1;
                end
                else if (func_reg == FUNC_DEL && ram_rdata[off_reg])
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata & ~bit_sel;
                    total_next = total_reg - 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (|scan_word)
                begin
                    found_next = 1'b1;
                    fidx_next  = ELEM_W'(base_reg + POS_W'(scan_idx));
                    state_next = ST_DONE;
                end
                else if (next_base >= POS_W'(lim_reg))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = addr_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                    off_next  = '0;
                    base_next = next_base;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    res_was_next   = was_reg;
                    res_found_next = found_reg;
                    res_fidx_next  = fidx_reg;
                    res_count_next = total_reg;
                    res_oor_next   = oor_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.valid        = res_valid_reg;
    assign res.was_member   = res_was_reg;
    assign res.found        = res_found_reg;
    assign res.found_index  = res_fidx_reg;
    assign res.member_count = res_count_reg;
    assign res.out_of_range = res_oor_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= MAX_MEMBERS)
        else $error("member count above element range");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_found_reg |-> !res_oor_reg && !res_was_reg)
        else $error("find result carries element flags");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> total_reg == '0 && ram_we && ram_wdata == '0)
        else $error("clear sweep not zeroing");
endmodule
